FILE: rtl/core/smpr_pkg.sv
// ----------------------------------------------------------------------------
// smpr_pkg
// Shared codes, state type and controller/datapath interface structs for the
// stable max-priority release store.
// ----------------------------------------------------------------------------
package smpr_pkg;

    // Function codes of an input item
    localparam logic [1:0] FUNC_ARRIVE  = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_DRAIN   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_RELEASED = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;

    // Most results one item may cause
    localparam logic [6:0] MAX_OUT = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARR_RESP,
        ST_INS_READ,
        ST_INS_STEP,
        ST_INS_HEAD,
        ST_REL_READ,
        ST_REL_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;      // capture accepted input item
        logic load_resp;    // load arrive response into output register
        logic rd_start;     // read tail entry, k <= fill-1
        logic rd_next;      // read entry k-1, k <= k-1
        logic rel_rd;       // read head entry
        logic wr_entry;     // move read entry to slot k+1
        logic wr_new_k;     // place new entry at slot k+1
        logic wr_new_head;  // place new entry at slot 0
        logic ins_done;     // insertion complete, fill++
        logic rel_out;      // emit head entry, pop it
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic reject;       // store full or arrival numbers used up
        logic fill_zero;
        logic rem_zero;     // nothing left to release for this item
        logic ge;           // read entry ranks at or above new entry
        logic k_zero;
        logic out_free;     // output register can take a result
    } sts_t;

endpackage

FILE: rtl/core/smpr_ctrl.sv
// ----------------------------------------------------------------------------
// smpr_ctrl
// Sequencer for arrive (insertion by backward shift) and release/drain
// (pop from head, one result at a time).
// ----------------------------------------------------------------------------
module smpr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      func,
    output logic            in_ready,
    output smpr_pkg::cmd_t  cmd,
    input  smpr_pkg::sts_t  sts
);

    smpr_pkg::state_t state_reg;
    smpr_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && (state_reg == smpr_pkg::ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (func) inside
                        smpr_pkg::FUNC_ARRIVE:  state_next = smpr_pkg::ST_ARR_RESP;
                        smpr_pkg::FUNC_RELEASE,
                        smpr_pkg::FUNC_DRAIN:   state_next = smpr_pkg::ST_REL_READ;
                        default:                state_next = smpr_pkg::ST_IDLE;
                    endcase
                end
            end
            smpr_pkg::ST_ARR_RESP:
            begin
                if (sts.out_free)
                begin
                    if (sts.reject)
                        state_next = smpr_pkg::ST_IDLE;
                    else if (sts.fill_zero)
                        state_next = smpr_pkg::ST_INS_HEAD;
                    else
                        state_next = smpr_pkg::ST_INS_READ;
                end
            end
            smpr_pkg::ST_INS_READ:
            begin
                state_next = smpr_pkg::ST_INS_STEP;
            end
            smpr_pkg::ST_INS_STEP:
            begin
                if (sts.ge)
                    state_next = smpr_pkg::ST_IDLE;
                else if (sts.k_zero)
                    state_next = smpr_pkg::ST_INS_HEAD;
            end
            smpr_pkg::ST_INS_HEAD:
            begin
                state_next = smpr_pkg::ST_IDLE;
            end
            smpr_pkg::ST_REL_READ:
            begin
                state_next = sts.rem_zero ? smpr_pkg::ST_IDLE : smpr_pkg::ST_REL_OUT;
            end
            smpr_pkg::ST_REL_OUT:
            begin
                if (sts.out_free)
                    state_next = smpr_pkg::ST_REL_READ;
            end
            default:
            begin
                state_next = smpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            smpr_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_in  = accept;
            end
            smpr_pkg::ST_ARR_RESP:
            begin
                cmd.load_resp = sts.out_free;
            end
            smpr_pkg::ST_INS_READ:
            begin
                cmd.rd_start = 1'b1;
            end
            smpr_pkg::ST_INS_STEP:
            begin
                if (sts.ge)
                begin
                    cmd.wr_new_k = 1'b1;
                    cmd.ins_done = 1'b1;
                end
                else
                begin
                    cmd.wr_entry = 1'b1;
                    cmd.rd_next  = !sts.k_zero;
                end
            end
            smpr_pkg::ST_INS_HEAD:
            begin
                cmd.wr_new_head = 1'b1;
                cmd.ins_done    = 1'b1;
            end
            smpr_pkg::ST_REL_READ:
            begin
                cmd.rel_rd = !sts.rem_zero;
            end
            smpr_pkg::ST_REL_OUT:
            begin
                cmd.rel_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/smpr_dp.sv
// ----------------------------------------------------------------------------
// smpr_dp
// Sorted entry store held as a ring in memory (best entry at head), with
// fill/arrival counters, insertion compare and the output register.
// ----------------------------------------------------------------------------
module smpr_dp #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smpr_pkg::cmd_t     cmd,
    output smpr_pkg::sts_t     sts,
    input  logic [1:0]         func,
    input  logic signed [31:0] guest_value,
    input  logic [6:0]         release_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        arrival_number,
    output logic [1:0]         status,
    output logic               last
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;
    localparam int ENT_W  = 48;

    logic [ENT_W-1:0]  mem [CAPACITY];

    logic [IDX_W-1:0]  head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [15:0]       next_arrival_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [6:0]        rem_reg;
    logic signed [31:0] new_value_reg;
    logic [15:0]       new_num_reg;
    logic signed [31:0] rd_value_reg;
    logic [15:0]       rd_arrival_reg;

    logic              out_valid_reg;
    logic [15:0]       arrival_number_reg;
    logic [1:0]        status_reg;
    logic              last_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [6:0]        want;
    logic [CMP_W-1:0]  want_ext;
    logic [CMP_W-1:0]  fill_ext;
    logic [6:0]        rem_init;
    logic [IDX_W-1:0]  fill_m1;

    // Logical slot to physical address: head + slot, wrapped once
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                              input logic [IDX_W-1:0] slot);
        logic [IDX_W:0] sum;
        sum = {1'b0, hd} + {1'b0, slot};
        if (sum >= (IDX_W+1)'(CAPACITY))
            sum = sum - (IDX_W+1)'(CAPACITY);
        return sum[IDX_W-1:0];
    endfunction

    // Status to controller
    assign sts.reject    = (fill_reg == FILL_W'(CAPACITY)) || (next_arrival_reg == 16'd0);
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.rem_zero  = (rem_reg == 7'd0);
    assign sts.ge        = (rd_value_reg >= new_value_reg);
    assign sts.k_zero    = (k_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Release count: saturate, then bound by entries held
    assign want     = (func == smpr_pkg::FUNC_RELEASE && release_count < smpr_pkg::MAX_OUT)
                      ? release_count : smpr_pkg::MAX_OUT;
    assign want_ext = CMP_W'(want);
    assign fill_ext = CMP_W'(fill_reg);
    assign rem_init = (want_ext < fill_ext) ? want : 7'(fill_reg);
    assign fill_m1  = IDX_W'(fill_reg - FILL_W'(1));

    // Memory read address
    always_comb
    begin
        rd_en   = cmd.rd_start || cmd.rd_next || cmd.rel_rd;
        rd_addr = head_reg;
        if (cmd.rd_start)
            rd_addr = phys(head_reg, fill_m1);
        else if (cmd.rd_next)
            rd_addr = phys(head_reg, k_reg - IDX_W'(1));
    end

    // Memory write address and data
    always_comb
    begin
        wr_en   = cmd.wr_entry || cmd.wr_new_k || cmd.wr_new_head;
        wr_addr = cmd.wr_new_head ? head_reg : phys(head_reg, k_reg + IDX_W'(1));
        wr_data = cmd.wr_entry ? {rd_value_reg, rd_arrival_reg}
                               : {new_value_reg, new_num_reg};
    end

    // Entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            {rd_value_reg, rd_arrival_reg} <= mem[rd_addr];
    end

    // Item payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            new_value_reg <= guest_value;
        if (cmd.load_resp)
            new_num_reg <= next_arrival_reg;
        if (cmd.rd_start)
            k_reg <= fill_m1;
        else if (cmd.rd_next)
            k_reg <= k_reg - IDX_W'(1);
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            fill_reg         <= '0;
            next_arrival_reg <= 16'd1;
            rem_reg          <= '0;
        end
        else
        begin
            if (cmd.load_in)
                rem_reg <= rem_init;
            else if (cmd.rel_out)
                rem_reg <= rem_reg - 7'd1;

            if (cmd.load_resp && !sts.reject)
                next_arrival_reg <= next_arrival_reg + 16'd1;

            if (cmd.ins_done)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (cmd.rel_out)
                fill_reg <= fill_reg - FILL_W'(1);

            if (cmd.rel_out)
                head_reg <= (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_resp || cmd.rel_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_resp)
        begin
            arrival_number_reg <= sts.reject ? 16'd0 : next_arrival_reg;
            status_reg         <= sts.reject ? smpr_pkg::STAT_REJECTED
                                             : smpr_pkg::STAT_ACCEPTED;
            last_reg           <= 1'b1;
        end
        else if (cmd.rel_out)
        begin
            arrival_number_reg <= rd_arrival_reg;
            status_reg         <= smpr_pkg::STAT_RELEASED;
            last_reg           <= (rem_reg == 7'd1);
        end
    end

    assign out_valid      = out_valid_reg;
    assign arrival_number = arrival_number_reg;
    assign status         = status_reg;
    assign last           = last_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rel_out |-> (fill_reg != '0) && (rem_reg != 7'd0))
        else $error("pop from empty store or past release count");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_done |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("insertion did not grow fill count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_resp || cmd.rel_out) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

endmodule

FILE: rtl/core/stable_max_priority_release.sv
// ----------------------------------------------------------------------------
// stable_max_priority_release
// Priority store with stable ordering: highest value first, ties by arrival.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): func, guest_value, release_count.
//   Arrive inserts guest_value and answers one item with its arrival number
//   (status accepted) or number 0 (status rejected: store full or numbers
//   used up). Release gives up to release_count entries (saturated at 64),
//   drain up to 64; an empty store gives no results. Code 3 is ignored.
// Output channel (out_valid/out_ready): arrival_number, status, last; last
//   marks the final result caused by an input item.
// Timing: one item at a time. An arrive first loads its answer into the output
//   register, then moves each entry that ranks below the new one back one slot
//   (one memory read and one write per step) and writes the new entry; a
//   release, for each result, reads the head entry and then outputs it.
// The store is a ring in memory, sorted best first; no clearing pass is
//   needed after reset, counters clear at once (next arrival number is 1).
// A stalled receiver holds the output register; the block waits for it before
//   loading the next result and accepts no new item meanwhile.
// ----------------------------------------------------------------------------
module stable_max_priority_release #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] guest_value,
    input  logic [6:0]         release_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        arrival_number,
    output logic [1:0]         status,
    output logic               last
);

    smpr_pkg::cmd_t cmd;
    smpr_pkg::sts_t sts;

    smpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    smpr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .guest_value    (guest_value),
        .release_count  (release_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .arrival_number (arrival_number),
        .status         (status),
        .last           (last)
    );

endmodule
